### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL, included by pam_move_core. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/pam_pkg.sv
package pam_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRIPPER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_BAND  = 3'd7;

    // Fixed register widths
    localparam int TIMEOUT_W = 16;
    localparam int TICK_W    = 8;
    // Phase counter holds up to five times the largest off time
    localparam int PHASE_W   = 11;

    localparam int NEAR_FACTOR = 5;

    // Reset values
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd5000;
    localparam logic [TICK_W-1:0]    ON_TICKS_RST  = 8'd10;
    localparam logic [TICK_W-1:0]    OFF_TICKS_RST = 8'd10;
    localparam int                   TOLERANCE_RST = 8;
    localparam int                   NEAR_BAND_RST = 15;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_MOVING  = 3'd1,
        ST_REACHED = 3'd2,
        ST_INVALID = 3'd3,
        ST_LIMIT   = 3'd4,
        ST_TIMEOUT = 3'd5
    } pam_status_t;

    typedef struct packed {
        logic        motor_enable;
        logic        extend_direction;
        logic        busy;
        pam_status_t status;
    } pam_result_t;

endpackage

### hw/rtl/pulsed_actuator_position_move_top.sv
// Pulsed bang-bang position controller for a linear actuator. Each input
// transaction is either a start (target plus position sample) or a tick
// (position sample), and yields exactly one result transaction carrying the
// motor enable, direction, busy flag and status. The block accepts one
// transaction per clock cycle, back to back, while the result slot is free
// or being emptied; an accepted transaction is held in the input register
// until then, is worked out by the core and is loaded into the result
// register, which offers it on out_valid. The rate is set by the state
// update between the input and result registers. Configuration
// registers are written through a separate write channel that is always
// ready; write them only while no transaction is in flight. Registers are
// read live, so a write between moves or during a move takes effect at once.
module pulsed_actuator_position_move_top #(
    parameter int POSITION_BITS = 10,
    parameter int TIMER_BITS    = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pam_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [((POSITION_BITS > pam_pkg::TIMEOUT_W) ?
                   POSITION_BITS : pam_pkg::TIMEOUT_W)-1:0] cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   action,
    input  logic [POSITION_BITS-1:0]               target_position,
    input  logic [POSITION_BITS-1:0]               position_sample,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   motor_enable,
    output logic                                   extend_direction,
    output logic                                   busy_res,
    output logic [2:0]                             move_status
);
    import pam_pkg::*;

    localparam int CFG_DATA_W = (POSITION_BITS > TIMEOUT_W) ? POSITION_BITS : TIMEOUT_W;

    logic [POSITION_BITS-1:0] range_min;
    logic [POSITION_BITS-1:0] range_max;
    logic                     gripper_mode;
    logic [POSITION_BITS-1:0] arrive_tolerance;
    logic [TIMEOUT_W-1:0]     timeout_ticks;
    logic [TICK_W-1:0]        on_ticks;
    logic [TICK_W-1:0]        off_ticks;
    logic [POSITION_BITS-1:0] near_band;

    // Input register: holds one accepted transaction until the core takes it
    logic                     in_vld_reg;
    logic                     action_reg;
    logic [POSITION_BITS-1:0] target_reg;
    logic [POSITION_BITS-1:0] sample_reg;

    // Result register: parts the core from the downstream consumer
    logic                     out_vld_reg;
    pam_result_t              res_reg;
    pam_result_t              res_next;

    logic                     advance;

    // Configuration writes never stall
    assign cfg_ready = 1'b1;

    pam_cfg_regs #(
        .POSITION_BITS (POSITION_BITS),
        .DATA_W        (CFG_DATA_W)
    ) u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .wr_en            (cfg_valid && cfg_ready),
        .wr_index         (cfg_index),
        .wr_data          (cfg_data),
        .range_min        (range_min),
        .range_max        (range_max),
        .gripper_mode     (gripper_mode),
        .arrive_tolerance (arrive_tolerance),
        .timeout_ticks    (timeout_ticks),
        .on_ticks         (on_ticks),
        .off_ticks        (off_ticks),
        .near_band        (near_band)
    );

    // Advance the held transaction into the core whenever the result slot is
    // free or is being emptied this cycle
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    // Payload needs no reset; load only on acceptance
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            target_reg <= target_position;
            sample_reg <= position_sample;
        end
    end

    pam_move_core #(
        .POSITION_BITS (POSITION_BITS),
        .TIMER_BITS    (TIMER_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .action           (action_reg),
        .target_position  (target_reg),
        .position_sample  (sample_reg),
        .range_min        (range_min),
        .range_max        (range_max),
        .gripper_mode     (gripper_mode),
        .arrive_tolerance (arrive_tolerance),
        .timeout_ticks    (timeout_ticks),
        .on_ticks         (on_ticks),
        .off_ticks        (off_ticks),
        .near_band        (near_band),
        .result           (res_next)
    );

    // Fill the result slot on advance, drop it once the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_vld_reg;
    assign motor_enable     = res_reg.motor_enable;
    assign extend_direction = res_reg.extend_direction;
    assign busy_res         = res_reg.busy;
    assign move_status      = res_reg.status;

endmodule

### hw/rtl/pam_cfg_regs.sv
module pam_cfg_regs #(
    parameter int POSITION_BITS = 10,
    parameter int DATA_W        = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [pam_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [DATA_W-1:0]               wr_data,
    output logic [POSITION_BITS-1:0]        range_min,
    output logic [POSITION_BITS-1:0]        range_max,
    output logic                            gripper_mode,
    output logic [POSITION_BITS-1:0]        arrive_tolerance,
    output logic [pam_pkg::TIMEOUT_W-1:0]   timeout_ticks,
    output logic [pam_pkg::TICK_W-1:0]      on_ticks,
    output logic [pam_pkg::TICK_W-1:0]      off_ticks,
    output logic [POSITION_BITS-1:0]        near_band
);
    import pam_pkg::*;

    logic [POSITION_BITS-1:0] range_min_reg;
    logic [POSITION_BITS-1:0] range_max_reg;
    logic                     gripper_reg;
    logic [POSITION_BITS-1:0] tolerance_reg;
    logic [TIMEOUT_W-1:0]     timeout_reg;
    logic [TICK_W-1:0]        on_ticks_reg;
    logic [TICK_W-1:0]        off_ticks_reg;
    logic [POSITION_BITS-1:0] near_band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= '0;
            range_max_reg <= '1;
            gripper_reg   <= 1'b0;
            tolerance_reg <= POSITION_BITS'(TOLERANCE_RST);
            timeout_reg   <= TIMEOUT_RST;
            on_ticks_reg  <= ON_TICKS_RST;
            off_ticks_reg <= OFF_TICKS_RST;
            near_band_reg <= POSITION_BITS'(NEAR_BAND_RST);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_RANGE_MIN: range_min_reg <= wr_data[POSITION_BITS-1:0];
                CFG_RANGE_MAX: range_max_reg <= wr_data[POSITION_BITS-1:0];
                CFG_GRIPPER:   gripper_reg   <= wr_data[0];
                CFG_TOLERANCE: tolerance_reg <= wr_data[POSITION_BITS-1:0];
                CFG_TIMEOUT:   timeout_reg   <= wr_data[TIMEOUT_W-1:0];
                CFG_ON_TICKS:  on_ticks_reg  <= wr_data[TICK_W-1:0];
                CFG_OFF_TICKS: off_ticks_reg <= wr_data[TICK_W-1:0];
                CFG_NEAR_BAND: near_band_reg <= wr_data[POSITION_BITS-1:0];
                default:       ;
            endcase
        end
    end

    assign range_min        = range_min_reg;
    assign range_max        = range_max_reg;
    assign gripper_mode     = gripper_reg;
    assign arrive_tolerance = tolerance_reg;
    assign timeout_ticks    = timeout_reg;
    assign on_ticks         = on_ticks_reg;
    assign off_ticks        = off_ticks_reg;
    assign near_band        = near_band_reg;

endmodule

### hw/rtl/pam_move_core.sv
`include "assert_macros.svh"

module pam_move_core #(
    parameter int POSITION_BITS = 10,
    parameter int TIMER_BITS    = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic                            action,
    input  logic [POSITION_BITS-1:0]        target_position,
    input  logic [POSITION_BITS-1:0]        position_sample,
    input  logic [POSITION_BITS-1:0]        range_min,
    input  logic [POSITION_BITS-1:0]        range_max,
    input  logic                            gripper_mode,
    input  logic [POSITION_BITS-1:0]        arrive_tolerance,
    input  logic [pam_pkg::TIMEOUT_W-1:0]   timeout_ticks,
    input  logic [pam_pkg::TICK_W-1:0]      on_ticks,
    input  logic [pam_pkg::TICK_W-1:0]      off_ticks,
    input  logic [POSITION_BITS-1:0]        near_band,
    output pam_pkg::pam_result_t            result
);
    import pam_pkg::*;

    localparam int TCMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2
    } phase_t;

    phase_t                   phase_reg,   phase_next;
    logic [PHASE_W-1:0]       cnt_reg,     cnt_next;
    logic [TIMER_BITS-1:0]    elapsed_reg, elapsed_next;
    logic [POSITION_BITS-1:0] target_reg,  target_next;
    logic                     extend_reg,  extend_next;
    pam_status_t              status_reg,  status_next;

    logic [POSITION_BITS-1:0] ref_pos;
    logic [POSITION_BITS-1:0] err;
    logic                     arrived;
    logic                     near;
    logic                     above;
    logic                     below;
    logic                     new_extend;
    logic                     heading_back;
    logic                     fault;
    logic                     do_boundary;
    logic                     enable;
    logic [TIMER_BITS-1:0]    elapsed_inc;

    // On a start the error is taken against the new target, otherwise the held one
    assign ref_pos     = action ? target_position : target_reg;
    assign err         = (position_sample > ref_pos) ? position_sample - ref_pos
                                                     : ref_pos - position_sample;
    assign arrived     = err < arrive_tolerance;
    assign near        = err < near_band;
    assign above       = position_sample > range_max;
    assign below       = position_sample < range_min;
    assign new_extend  = gripper_mode ? (position_sample < target_position)
                                      : (position_sample > target_position);
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        elapsed_next = elapsed_reg;
        target_next  = target_reg;
        extend_next  = extend_reg;
        status_next  = status_reg;
        do_boundary  = 1'b0;
        heading_back = 1'b0;
        fault        = 1'b0;
        enable       = 1'b0;

        if (step)
        begin
            if (action)
            begin
                phase_next = PH_IDLE;
                cnt_next   = '0;
                if (target_position < range_min || target_position > range_max)
                begin
                    status_next = ST_INVALID;
                end
                else if (arrived)
                begin
                    target_next = target_position;
                    status_next = ST_REACHED;
                end
                else
                begin
                    target_next  = target_position;
                    extend_next  = new_extend;
                    elapsed_next = '0;
                    do_boundary  = 1'b1;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                elapsed_next = elapsed_inc;
                if (phase_reg == PH_ON && cnt_reg == '0)
                begin
                    phase_next = PH_OFF;
                    cnt_next   = near ? PHASE_W'(off_ticks) * PHASE_W'(NEAR_FACTOR)
                                      : PHASE_W'(off_ticks);
                end
                if (phase_next == PH_OFF && cnt_next == '0)
                begin
                    do_boundary = 1'b1;
                end
            end

            // Out of range and not heading back in
            if (gripper_mode)
                heading_back = (above && !extend_next) || (below && extend_next);
            else
                heading_back = (above && extend_next) || (below && !extend_next);
            fault = (above || below) && !heading_back;

            if (do_boundary)
            begin
                if (arrived)
                begin
                    phase_next  = PH_IDLE;
                    cnt_next    = '0;
                    status_next = ST_REACHED;
                end
                else if (fault)
                begin
                    phase_next  = PH_IDLE;
                    cnt_next    = '0;
                    status_next = ST_LIMIT;
                end
                else if (TCMP_W'(elapsed_next) > TCMP_W'(timeout_ticks))
                begin
                    phase_next  = PH_IDLE;
                    cnt_next    = '0;
                    status_next = ST_TIMEOUT;
                end
                else
                begin
                    phase_next  = PH_ON;
                    cnt_next    = (on_ticks == '0) ? PHASE_W'(1) : PHASE_W'(on_ticks);
                    status_next = ST_MOVING;
                end
            end

            if (phase_next != PH_IDLE && cnt_next != '0)
            begin
                cnt_next = cnt_next - PHASE_W'(1);
                enable   = (phase_next == PH_ON);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            elapsed_reg <= '0;
            target_reg  <= '0;
            extend_reg  <= 1'b0;
            status_reg  <= ST_IDLE;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            elapsed_reg <= elapsed_next;
            target_reg  <= target_next;
            extend_reg  <= extend_next;
            status_reg  <= status_next;
        end
    end

    assign result.motor_enable     = enable;
    assign result.extend_direction = extend_next;
    assign result.busy             = (phase_next != PH_IDLE);
    assign result.status           = status_next;

    `ASSERT_IMPL(a_idle_cnt_zero, phase_reg == PH_IDLE, cnt_reg == '0)
    `ASSERT_IMPL(a_enable_needs_move, result.motor_enable, result.busy && step)
    `ASSERT_NEXT(a_elapsed_monotonic, step && !action, elapsed_reg >= $past(elapsed_reg))

endmodule

### tb/sv/tb_pulsed_actuator_position_move_top.sv
`timescale 1ns / 1ps

import pam_pkg::*;

typedef enum logic [1:0] {
    PH_IDLE,
    PH_ON,
    PH_OFF
} move_phase_t;

// Tracks the controller's move state and holds the results it should produce.
class move_scoreboard;
    logic [9:0]  range_lo;
    logic [9:0]  range_hi;
    logic        gripper;
    logic [9:0]  tolerance;
    logic [15:0] timeout_lim;
    logic [7:0]  on_len;
    logic [7:0]  off_len;
    logic [9:0]  near_band;

    move_phase_t phase;
    logic [10:0] phase_left;
    logic [15:0] elapsed;
    logic [9:0]  held_target;
    logic        extend;
    pam_status_t status;
    logic        enable_now;

    pam_result_t expected_q[$];
    int          mismatches;
    int          results_seen;
    int          status_seen[6];

    function new();
        range_lo     = '0;
        range_hi     = 10'd1023;
        gripper      = 1'b0;
        tolerance    = 10'(TOLERANCE_RST);
        timeout_lim  = TIMEOUT_RST;
        on_len       = ON_TICKS_RST;
        off_len      = OFF_TICKS_RST;
        near_band    = 10'(NEAR_BAND_RST);
        phase        = PH_IDLE;
        phase_left   = '0;
        elapsed      = '0;
        held_target  = '0;
        extend       = 1'b0;
        status       = ST_IDLE;
        enable_now   = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
    endfunction

    function int distance(logic [9:0] a, logic [9:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function bit busy();
        return phase != PH_IDLE;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        case (idx)
            CFG_RANGE_MIN: range_lo    = val[9:0];
            CFG_RANGE_MAX: range_hi    = val[9:0];
            CFG_GRIPPER:   gripper     = val[0];
            CFG_TOLERANCE: tolerance   = val[9:0];
            CFG_TIMEOUT:   timeout_lim = val;
            CFG_ON_TICKS:  on_len      = val[7:0];
            CFG_OFF_TICKS: off_len     = val[7:0];
            CFG_NEAR_BAND: near_band   = val[9:0];
            default: ;
        endcase
    endfunction

    // End of an on/off cycle: finish the move or start the next pulse.
    function void close_cycle(logic [9:0] smp);
        logic        above;
        logic        below;
        logic        heading_back;
        pam_status_t verdict;
        above = smp > range_hi;
        below = smp < range_lo;
        heading_back = gripper ? ((above && !extend) || (below && extend))
                               : ((above && extend) || (below && !extend));
        if (distance(smp, held_target) < int'(tolerance))
            verdict = ST_REACHED;
        else if ((above || below) && !heading_back)
            verdict = ST_LIMIT;
        else if (elapsed > timeout_lim)
            verdict = ST_TIMEOUT;
        else
            verdict = ST_MOVING;
        status = verdict;
        if (verdict == ST_MOVING)
        begin
            phase      = PH_ON;
            phase_left = (on_len == 0) ? 11'd1 : 11'(on_len);
        end
        else
        begin
            phase      = PH_IDLE;
            phase_left = '0;
        end
    endfunction

    function void note_item(logic act, logic [9:0] tgt, logic [9:0] smp);
        pam_result_t want;
        if (act)
        begin
            phase      = PH_IDLE;
            phase_left = '0;
            if (tgt < range_lo || tgt > range_hi)
                status = ST_INVALID;
            else if (distance(smp, tgt) < int'(tolerance))
            begin
                held_target = tgt;
                status      = ST_REACHED;
            end
            else
            begin
                held_target = tgt;
                extend      = gripper ? (smp < tgt) : (smp > tgt);
                elapsed     = '0;
                close_cycle(smp);
            end
        end
        else if (phase != PH_IDLE)
        begin
            if (elapsed != 16'hFFFF)
                elapsed = elapsed + 16'd1;
            if (phase == PH_ON && phase_left == 0)
            begin
                phase      = PH_OFF;
                phase_left = (distance(smp, held_target) < int'(near_band))
                           ? 11'(off_len) * 11'(NEAR_FACTOR) : 11'(off_len);
            end
            if (phase == PH_OFF && phase_left == 0)
                close_cycle(smp);
        end
        enable_now = 1'b0;
        if (phase != PH_IDLE && phase_left != 0)
        begin
            phase_left = phase_left - 11'd1;
            enable_now = (phase == PH_ON);
        end
        want.motor_enable     = enable_now;
        want.extend_direction = extend;
        want.busy             = (phase != PH_IDLE);
        want.status           = status;
        expected_q.push_back(want);
    endfunction

    function void compare_field(string field, logic [2:0] want, logic [2:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 30)
                $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    function void check_result(pam_result_t got);
        pam_result_t want;
        results_seen++;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 30)
                $display("%0t ns: result expected none, got en %b dir %b busy %b status %0d",
                         $time, got.motor_enable, got.extend_direction, got.busy, got.status);
            return;
        end
        want = expected_q.pop_front();
        status_seen[int'(want.status)]++;
        compare_field("motor_enable", 3'(want.motor_enable), 3'(got.motor_enable));
        compare_field("extend_direction", 3'(want.extend_direction),
                      3'(got.extend_direction));
        compare_field("busy_res", 3'(want.busy), 3'(got.busy));
        compare_field("move_status", want.status, got.status);
    endfunction
endclass

module tb_pulsed_actuator_position_move_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 10;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [9:0]  target_position;
    logic [9:0]  position_sample;
    logic        out_valid;
    logic        out_ready;
    logic        motor_enable;
    logic        extend_direction;
    logic        busy_res;
    logic [2:0]  move_status;

    move_scoreboard sb;

    // Sender state shared by send_item and the stimulus block
    bit gap_free      = 1'b0;
    int items_sent    = 0;
    int counted_items = 0;

    pulsed_actuator_position_move_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .target_position  (target_position),
        .position_sample  (position_sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .motor_enable     (motor_enable),
        .extend_direction (extend_direction),
        .busy_res         (busy_res),
        .move_status      (move_status)
    );

    // 12 ns clock period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int clamp_pos(int v);
        return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
    endfunction

    // Present one input transaction after a random gap and hold it until taken.
    // Valid is left high on return so that a back-to-back transaction never
    // sees it dropped and raised within one time step; a later gap or drain lowers it.
    task automatic send_item(input logic act, input logic [9:0] tgt, input logic [9:0] smp);
        int gap;
        gap = gap_free ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        action          <= act;
        target_position <= tgt;
        position_sample <= smp;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        // Idle ticks leave the block's state unchanged, so leave them out of the tally
        if (act || sb.busy())
            counted_items++;
        sb.note_item(act, tgt, smp);
        items_sent++;
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic hold_until_drained(input int settle);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // One register write; valid stays high so a burst of writes runs back to back.
    task automatic post_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(input logic [9:0] lo, input logic [9:0] hi, input logic grip,
                             input logic [9:0] tol, input logic [15:0] tmo,
                             input logic [7:0] on_t, input logic [7:0] off_t,
                             input logic [9:0] near);
        post_reg(CFG_RANGE_MIN, 16'(lo));
        post_reg(CFG_RANGE_MAX, 16'(hi));
        post_reg(CFG_GRIPPER, 16'(grip));
        post_reg(CFG_TOLERANCE, 16'(tol));
        post_reg(CFG_TIMEOUT, tmo);
        post_reg(CFG_ON_TICKS, 16'(on_t));
        post_reg(CFG_OFF_TICKS, 16'(off_t));
        post_reg(CFG_NEAR_BAND, 16'(near));
        cfg_valid <= 1'b0;
    endtask

    // Result side: stall at random before each transaction, with
    // occasional stretches of ready held high, and check every result taken.
    initial
    begin : result_sink
        int          stall;
        bit          stall_free;
        pam_result_t got;
        stall_free = 1'b0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                stall_free = !stall_free;
            stall = stall_free ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            got.motor_enable     = motor_enable;
            got.extend_direction = extend_direction;
            got.busy             = busy_res;
            got.status           = pam_status_t'(move_status);
            sb.check_result(got);
        end
    end

    // Abort when no channel has moved a transaction for too long, or when the run hits its overall cycle limit.
    initial
    begin : watchdog
        int quiet;
        int total;
        quiet = 0;
        total = 0;
        while (quiet < QUIET_LIMIT && total < CYCLE_LIMIT)
        begin
            @(posedge clk);
            total++;
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: run stalled after %0d cycles (%0d quiet)", $time, total, quiet);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int         quota;
        int         phase_start;
        int         n;
        int         k;
        int         pos;
        int         step;
        int         dir;
        int         pick;
        bit         wild;
        logic [9:0] tgt;

        sb              = new();
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_RANGE_MIN;
        cfg_data        = '0;
        in_valid        = 1'b0;
        action          = 1'b0;
        target_position = '0;
        position_sample = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings first
        send_item(1'b0, 10'd1023, 10'd1023);    // tick while idle: nothing moves
        send_item(1'b1, 10'd512, 10'd515);      // already inside tolerance on start
        send_item(1'b1, 10'd1023, 10'd0);       // full-scale move, retract
        // Run out the on pulse; the last tick lands near the target, so the
        // slow off time is chosen
        for (k = 0; k < 10; k++)
            send_item(1'b0, 10'd0, 10'(1005 + k));
        send_item(1'b1, 10'd0, 10'd1023);       // restart while busy, extend
        hold_until_drained(4);

        // Narrow range, gripper sense, zero on and off times, tiny timeout
        configure(10'd200, 10'd800, 1'b1, 10'd8, 16'd3, 8'd0, 8'd0, 10'd10);
        send_item(1'b1, 10'd100, 10'd500);      // target below the range
        send_item(1'b1, 10'd1023, 10'd500);     // target above the range
        send_item(1'b1, 10'd800, 10'd200);      // gripper: extend towards target
        send_item(1'b0, 10'd0, 10'd150);        // below range but heading back
        send_item(1'b0, 10'd0, 10'd900);        // above range moving away: fault
        send_item(1'b1, 10'd800, 10'd200);
        for (k = 0; k < 4; k++)
            send_item(1'b0, 10'd0, 10'd500);    // fourth tick exceeds the timeout
        send_item(1'b0, 10'd1023, 10'd0);

        // Random moves under a sequence of settings, extremes first
        for (int ph = 0; ph < PHASES; ph++)
        begin
            hold_until_drained(4);
            case (ph)
                0:
                begin
                    configure(10'd100, 10'd900, 1'b0, 10'd4, 16'd300, 8'd3, 8'd2, 10'd20);
                    quota = 220;
                end
                1:
                begin
                    // zero tolerance never arrives, so a move that runs its course times out
                    configure(10'd0, 10'd1023, 1'b1, 10'd0, 16'd40, 8'd1, 8'd0, 10'd0);
                    quota = 200;
                end
                2:
                begin
                    configure(10'd0, 10'd1023, 1'b0, 10'd1023, 16'hFFFF, 8'd255, 8'd255,
                              10'd1023);
                    quota = 60;
                end
                3:
                begin
                    configure(10'd512, 10'd512, 1'b1, 10'd2, 16'd0, 8'd0, 8'd0, 10'd1);
                    quota = 100;
                end
                4:
                begin
                    // inverted range refuses every target
                    configure(10'd700, 10'd300, 1'b0, 10'd8, 16'd100, 8'd2, 8'd1, 10'd30);
                    quota = 60;
                end
                default:
                begin
                    configure(10'($urandom_range(0, 400)), 10'($urandom_range(600, 1023)),
                              1'($urandom_range(0, 1)), 10'($urandom_range(0, 20)),
                              ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 400)),
                              8'($urandom_range(0, 8)), 8'($urandom_range(0, 6)),
                              10'($urandom_range(0, 60)));
                    quota = 200;
                end
            endcase

            phase_start = counted_items;
            while (counted_items - phase_start < quota)
            begin
                if ($urandom_range(0, 6) == 0)
                    gap_free = !gap_free;
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    hold_until_drained(0);
                else if (pick < 3)
                begin
                    // noise: arbitrary transactions, starts and ticks mixed
                    repeat ($urandom_range(1, 6))
                        send_item(1'($urandom_range(0, 1)), 10'($urandom), 10'($urandom));
                end
                else
                begin
                    // A plausible move: the plant closes on the target while
                    // driven; a wild move keeps going and overshoots, which
                    // near the range edges ends in a limit fault.
                    wild = ($urandom_range(0, 4) == 0);
                    if (sb.range_lo <= sb.range_hi && $urandom_range(0, 7) != 0)
                    begin
                        if (wild)
                            tgt = 10'(clamp_pos($urandom_range(0, 1)
                                      ? int'(sb.range_lo) + int'($urandom_range(0, 20))
                                      : int'(sb.range_hi) - int'($urandom_range(0, 20))));
                        else
                            tgt = 10'($urandom_range(sb.range_lo, sb.range_hi));
                    end
                    else
                        tgt = 10'($urandom);
                    if ($urandom_range(0, 7) == 0)
                        pos = $urandom_range(0, 1023);
                    else
                        pos = clamp_pos(int'(tgt) + int'($urandom_range(0, 160)) - 80);
                    dir = (pos < int'(tgt)) ? 1 : -1;
                    send_item(1'b1, tgt, 10'(pos));
                    n = $urandom_range(4, 150);
                    for (k = 0; k < n && sb.busy(); k++)
                    begin
                        if (sb.enable_now)
                        begin
                            step = $urandom_range(1, 6);
                            if (wild)
                                pos += dir * step;
                            else
                                pos += (pos < int'(tgt)) ? step : -step;
                        end
                        pos = clamp_pos(pos + int'($urandom_range(0, 2)) - 1);
                        // the odd glitched reading lands anywhere
                        if ($urandom_range(0, 39) == 0)
                            send_item(1'b0, 10'($urandom), 10'($urandom));
                        else
                            send_item(1'b0, 10'($urandom), 10'(pos));
                    end
                    if ($urandom_range(0, 4) == 0)
                        send_item(1'b0, 10'($urandom), 10'(pos));
                end
            end
        end

        hold_until_drained(20);
        $display("Covered %0d input transactions and %0d results across %0d register settings.",
                 items_sent, sb.results_seen, PHASES + 2);
        $display("Outcomes: idle %0d, moving %0d, reached %0d, refused %0d, limit %0d, timeout %0d.",
                 sb.status_seen[ST_IDLE], sb.status_seen[ST_MOVING],
                 sb.status_seen[ST_REACHED], sb.status_seen[ST_INVALID],
                 sb.status_seen[ST_LIMIT], sb.status_seen[ST_TIMEOUT]);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/pam_pkg.sv
hw/rtl/pam_cfg_regs.sv
hw/rtl/pam_move_core.sv
hw/rtl/pulsed_actuator_position_move_top.sv
tb/sv/tb_pulsed_actuator_position_move_top.sv
